[hdl/rat_pkg.sv]
// Shared types and constants for the region address translator.
package rat_pkg;

    localparam int REGION_ENTRIES_DEF = 64;
    localparam int ADDR_W = 64;

    // Command codes carried on the cmd port
    localparam logic [1:0] CMD_WRITE     = 2'd0;
    localparam logic [1:0] CMD_TO_ADDR   = 2'd1;
    localparam logic [1:0] CMD_TO_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DIST,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dump_start;
        logic [ADDR_W-1:0] dump_size;
        logic [ADDR_W-1:0] base_addr;
    } t_entry;

endpackage

[hdl/rat_table.sv]
// Region table memory: one write port, one registered read port.
module rat_table #(
    parameter int DEPTH = rat_pkg::REGION_ENTRIES_DEF,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  rat_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output rat_pkg::t_entry o_rd_data
);

    rat_pkg::t_entry r_mem [DEPTH];
    rat_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/region_address_translator.sv]
// Region address translator top level: command decode, table scan and result stage.
//
// Usage: present an item on the i_ ports with start high; it is taken at the
// rising edge where start is high and busy is low. Command 0 writes one table
// slot (start, size, base), marks it valid and gives no
// result. Command 1 translates a dump offset to a virtual address, command 2 a
// virtual address to a dump offset. Command 3 and writes to slots beyond the
// table are dropped.
// A query walks the whole table in memory, one entry per cycle through the
// single read port, keeping the best matching region, then forms the distance
// and after it the answer; the next item is taken as the result shows.
// The result on o_translated and o_hit is marked by o_strobe, high for a
// single cycle; the receiver cannot hold it off.
// After reset the block clears the valid flags of the table, one entry per
// cycle, keeping busy high until the whole table is cleared.
module region_address_translator #(
    parameter int REGION_ENTRIES = rat_pkg::REGION_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_cmd,
    input  logic [5:0]                 i_entry_index,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_dump_offset,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_dump_size,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_base_address,
    input  logic [rat_pkg::ADDR_W-1:0] i_query_address,
    output logic                       o_strobe,
    output logic [rat_pkg::ADDR_W-1:0] o_translated,
    output logic                       o_hit
);

    localparam int AW = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(REGION_ENTRIES - 1);

    rat_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_addr;
    logic            r_rd_vld;
    logic [1:0]      r_cmd;
    logic [rat_pkg::ADDR_W-1:0] r_query;
    logic            r_found;
    logic [rat_pkg::ADDR_W-1:0] r_best_start, r_best_size, r_best_to, r_dist;
    logic            r_strobe, r_hit;
    logic [rat_pkg::ADDR_W-1:0] r_translated;

    logic accept, is_query, is_write, wr_in_range;
    logic rd_en, clearing, addr_step, do_dist, do_fin;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    rat_pkg::t_entry wr_data, rd_data;
    logic [rat_pkg::ADDR_W-1:0] cand_from, cand_to;
    logic take, in_range;

    assign accept      = start && !busy;
    assign is_query    = (i_cmd == rat_pkg::CMD_TO_ADDR) || (i_cmd == rat_pkg::CMD_TO_OFFSET);
    assign is_write    = (i_cmd == rat_pkg::CMD_WRITE);
    assign wr_in_range = (32'(i_entry_index) < REGION_ENTRIES);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rat_pkg::ST_CLEAR: if (r_addr == LAST_ADDR) n_state = rat_pkg::ST_IDLE;
            rat_pkg::ST_IDLE:  if (accept && is_query) n_state = rat_pkg::ST_SCAN;
            rat_pkg::ST_SCAN:  if (r_addr == LAST_ADDR) n_state = rat_pkg::ST_LAST;
            rat_pkg::ST_LAST:  n_state = rat_pkg::ST_DIST;
            rat_pkg::ST_DIST:  n_state = rat_pkg::ST_FIN;
            rat_pkg::ST_FIN:   n_state = rat_pkg::ST_IDLE;
            default:           n_state = rat_pkg::ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        busy     = 1'b1;
        rd_en    = 1'b0;
        clearing = 1'b0;
        do_dist  = 1'b0;
        do_fin   = 1'b0;
        unique case (r_state)
            rat_pkg::ST_CLEAR: clearing = 1'b1;
            rat_pkg::ST_IDLE:  busy = 1'b0;
            rat_pkg::ST_SCAN:  rd_en = 1'b1;
            rat_pkg::ST_LAST:  ;
            rat_pkg::ST_DIST:  do_dist = 1'b1;
            rat_pkg::ST_FIN:   do_fin = 1'b1;
            default:           ;
        endcase
    end

    assign addr_step = clearing || rd_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rat_pkg::ST_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_strobe <= do_fin;
            if (addr_step) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);
            end
        end
    end

    // Table port: clearing pass or a write transaction, never both
    always_comb begin
        wr_data            = '0;
        wr_en              = clearing;
        wr_addr            = r_addr;
        if (!clearing) begin
            wr_en              = accept && is_write && wr_in_range;
            wr_addr            = AW'(i_entry_index);
            wr_data.valid      = 1'b1;
            wr_data.dump_start = i_entry_dump_offset;
            wr_data.dump_size  = i_entry_dump_size;
            wr_data.base_addr  = i_entry_base_address;
        end
    end

    rat_table #(
        .DEPTH (REGION_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Candidate compare on the entry read last cycle; ties go to the later index
    assign cand_from = (r_cmd == rat_pkg::CMD_TO_ADDR) ? rd_data.dump_start : rd_data.base_addr;
    assign cand_to   = (r_cmd == rat_pkg::CMD_TO_ADDR) ? rd_data.base_addr : rd_data.dump_start;
    assign take      = r_rd_vld && rd_data.valid && (cand_from <= r_query)
                       && (!r_found || (cand_from >= r_best_start));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (accept && is_query) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_cmd   <= i_cmd;
            r_query <= i_query_address;
        end
        if (take) begin
            r_best_start <= cand_from;
            r_best_size  <= rd_data.dump_size;
            r_best_to    <= cand_to;
        end
        if (do_dist) begin
            r_dist <= r_query - r_best_start;
        end
        if (do_fin) begin
            r_hit        <= in_range;
            r_translated <= in_range ? (r_best_to + r_dist) : '0;
        end
    end

    assign in_range = r_found && (r_dist <= r_best_size);

    assign o_strobe     = r_strobe;
    assign o_hit        = r_hit;
    assign o_translated = r_translated;

endmodule

[hdl/rat_checker.sv]
// Port-level checks for the region address translator, bound to the top level.
module rat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_cmd,
    input logic        o_strobe,
    input logic [63:0] o_translated,
    input logic        o_hit
);

    // Busy is high and no result shows right after reset
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy && !o_strobe)
        else $error("busy low or result shown right after reset");

    // A result lasts a single cycle
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    // A miss reports zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_translated == 64'd0)
        else $error("miss with non-zero translation");

    // An accepted query is followed by busy with no result strobe
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == rat_pkg::CMD_TO_ADDR || i_cmd == rat_pkg::CMD_TO_OFFSET)
        |=> busy && !o_strobe)
        else $error("query accepted without going busy");

endmodule

bind region_address_translator rat_checker u_rat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_cmd        (i_cmd),
    .o_strobe     (o_strobe),
    .o_translated (o_translated),
    .o_hit        (o_hit)
);

[tb/rat_checker.sv]
// Checker for the region address translator: predicts each translation and compares the results.
module rat_tb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [1:0]                 i_cmd,
    input  logic [5:0]                 i_entry_index,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_dump_offset,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_dump_size,
    input  logic [rat_pkg::ADDR_W-1:0] i_entry_base_address,
    input  logic [rat_pkg::ADDR_W-1:0] i_query_address,
    input  logic                       i_strobe,
    input  logic [rat_pkg::ADDR_W-1:0] i_translated,
    input  logic                       i_hit,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W             = rat_pkg::ADDR_W;
    localparam int REGION_ENTRIES_DEF = rat_pkg::REGION_ENTRIES_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] translated;
        logic              hit;
    } t_answer;

    rat_pkg::t_entry region_copy [REGION_ENTRIES_DEF];
    t_answer         answer_q [$];

    function automatic t_answer translate_query(logic [1:0] cmd, logic [ADDR_W-1:0] query);
        t_answer           ans;
        logic              found;
        logic [ADDR_W-1:0] best_from;
        logic [ADDR_W-1:0] from_val;
        logic [ADDR_W-1:0] span;
        int                best_k;
        ans       = '0;
        found     = 1'b0;
        best_from = '0;
        best_k    = 0;
        // Greatest start not above the query; a later slot wins a tie
        for (int k = 0; k < REGION_ENTRIES_DEF; k++) begin
            from_val = (cmd == rat_pkg::CMD_TO_ADDR) ? region_copy[k].dump_start
                                                     : region_copy[k].base_addr;
            if (region_copy[k].valid && from_val <= query
                    && (!found || from_val >= best_from)) begin
                found     = 1'b1;
                best_from = from_val;
                best_k    = k;
            end
        end
        if (found) begin
            span = query - best_from;
            if (span <= region_copy[best_k].dump_size) begin
                ans.translated = span + ((cmd == rat_pkg::CMD_TO_ADDR)
                                         ? region_copy[best_k].base_addr
                                         : region_copy[best_k].dump_start);
                ans.hit        = 1'b1;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_answer want;
        if (!i_rst_n) begin
            for (int k = 0; k < REGION_ENTRIES_DEF; k++) region_copy[k].valid = 1'b0;
            answer_q.delete();
        end else begin
            // Retire the finished transaction before taking the next one
            if (i_strobe) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result: translated %h hit %b", i_translated, i_hit);
                    o_fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_translated !== want.translated) begin
                        $error("translated: expected %h, actual %h", want.translated, i_translated);
                        o_fail_count++;
                    end
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %b, actual %b", want.hit, i_hit);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_cmd) inside
                    rat_pkg::CMD_WRITE: begin
                        if (i_entry_index < REGION_ENTRIES_DEF) begin
                            region_copy[i_entry_index].valid      = 1'b1;
                            region_copy[i_entry_index].dump_start = i_entry_dump_offset;
                            region_copy[i_entry_index].dump_size  = i_entry_dump_size;
                            region_copy[i_entry_index].base_addr  = i_entry_base_address;
                        end
                    end
                    rat_pkg::CMD_TO_ADDR, rat_pkg::CMD_TO_OFFSET: begin
                        answer_q = {answer_q, translate_query(i_cmd, i_query_address)};
                    end
                    default: ;  // drop: no result, no table change
                endcase
            end
        end
        o_pending = answer_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the region address translator: drives transactions and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ADDR_W             = rat_pkg::ADDR_W;
    localparam int         REGION_ENTRIES_DEF = rat_pkg::REGION_ENTRIES_DEF;
    localparam logic [1:0] CMD_IGNORED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1250;
    localparam int         DRAIN_CYCLES = REGION_ENTRIES_DEF + 8;

    typedef struct {
        logic [1:0]        cmd;
        logic [5:0]        index;
        logic [ADDR_W-1:0] dump_offset;
        logic [ADDR_W-1:0] dump_size;
        logic [ADDR_W-1:0] base_address;
        logic [ADDR_W-1:0] query;
    } t_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_cmd;
    logic [5:0]        i_entry_index;
    logic [ADDR_W-1:0] i_entry_dump_offset;
    logic [ADDR_W-1:0] i_entry_dump_size;
    logic [ADDR_W-1:0] i_entry_base_address;
    logic [ADDR_W-1:0] i_query_address;
    logic              o_strobe;
    logic [ADDR_W-1:0] o_translated;
    logic              o_hit;
    int                fail_count;
    int                pending;

    // Regions written so far, kept to aim queries and new regions at them
    bit [ADDR_W-1:0] wr_start [REGION_ENTRIES_DEF];
    bit [ADDR_W-1:0] wr_size  [REGION_ENTRIES_DEF];
    bit [ADDR_W-1:0] wr_base  [REGION_ENTRIES_DEF];
    bit              wr_used  [REGION_ENTRIES_DEF];
    int              used_slots [$];
    int unsigned     gap_pct [3] = '{7, 57, 0};

    region_address_translator u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cmd                (i_cmd),
        .i_entry_index        (i_entry_index),
        .i_entry_dump_offset  (i_entry_dump_offset),
        .i_entry_dump_size    (i_entry_dump_size),
        .i_entry_base_address (i_entry_base_address),
        .i_query_address      (i_query_address),
        .o_strobe             (o_strobe),
        .o_translated         (o_translated),
        .o_hit                (o_hit)
    );

    rat_tb_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_cmd                (i_cmd),
        .i_entry_index        (i_entry_index),
        .i_entry_dump_offset  (i_entry_dump_offset),
        .i_entry_dump_size    (i_entry_dump_size),
        .i_entry_base_address (i_entry_base_address),
        .i_query_address      (i_query_address),
        .i_strobe             (o_strobe),
        .i_translated         (o_translated),
        .i_hit                (o_hit),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_region_address(logic [ADDR_W-1:0] near);
        case ($urandom_range(0, 5))
            0:       return rand64();
            1:       return ADDR_W'($urandom_range(0, 4095));
            2:       return '1 - ADDR_W'($urandom_range(0, 255));
            3:       return near;  // tie with an existing region
            4:       return near + ADDR_W'($urandom_range(0, 64)) - ADDR_W'(32);
            default: return {32'h0, $urandom};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return ADDR_W'($urandom_range(0, 255));
            1:       return '0;
            2:       return rand64();
            3:       return '1;
            4:       return ADDR_W'($urandom_range(0, 1 << 20));
            default: return {32'h0, $urandom};
        endcase
    endfunction

    task automatic drive_item(t_item it);
        @(negedge i_clk);
        i_cmd                <= it.cmd;
        i_entry_index        <= it.index;
        i_entry_dump_offset  <= it.dump_offset;
        i_entry_dump_size    <= it.dump_size;
        i_entry_base_address <= it.base_address;
        i_query_address      <= it.query;
        start                <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        start                <= 1'b0;
        i_cmd                <= 2'($urandom);
        i_entry_index        <= 6'($urandom);
        i_entry_dump_offset  <= rand64();
        i_entry_dump_size    <= rand64();
        i_entry_base_address <= rand64();
        i_query_address      <= rand64();
    endtask

    task automatic drain_results();
        do idle_cycle(); while (pending != 0);
    endtask

    task automatic sender_gap(int unsigned pct);
        if ($urandom_range(0, 99) < pct)
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 3))
                idle_cycle();
    endtask

    task automatic send_write(int slot, logic [ADDR_W-1:0] dstart, logic [ADDR_W-1:0] dsize,
                              logic [ADDR_W-1:0] base);
        t_item it;
        it = '{rat_pkg::CMD_WRITE, 6'(slot), dstart, dsize, base, rand64()};
        drive_item(it);
        wr_start[slot] = dstart;
        wr_size[slot]  = dsize;
        wr_base[slot]  = base;
        if (!wr_used[slot]) begin
            wr_used[slot] = 1'b1;
            used_slots    = {used_slots, slot};
        end
    endtask

    task automatic send_query(logic [1:0] cmd, logic [ADDR_W-1:0] query);
        t_item it;
        it = '{cmd, 6'($urandom), rand64(), rand64(), rand64(), query};
        drive_item(it);
    endtask

    task automatic send_ignored();
        t_item it;
        it = '{CMD_IGNORED, 6'($urandom), rand64(), rand64(), rand64(), rand64()};
        drive_item(it);
    endtask

    task automatic random_write();
        int peer;
        peer = (used_slots.size() != 0) ? used_slots[$urandom_range(0, used_slots.size() - 1)] : 0;
        send_write($urandom_range(0, REGION_ENTRIES_DEF - 1), pick_region_address(wr_start[peer]),
                   pick_size(), pick_region_address(wr_base[peer]));
    endtask

    task automatic random_query();
        logic [1:0]        qcmd;
        logic [ADDR_W-1:0] from_val;
        logic [ADDR_W-1:0] size_val;
        logic [ADDR_W-1:0] offset;
        int                slot;
        qcmd = $urandom_range(0, 1) ? rat_pkg::CMD_TO_ADDR : rat_pkg::CMD_TO_OFFSET;
        if (used_slots.size() == 0 || $urandom_range(0, 9) == 0) begin
            send_query(qcmd, rand64());
        end else begin
            // Aim at a known region: its start, its inclusive end, just past it, just below it or inside it
            slot     = used_slots[$urandom_range(0, used_slots.size() - 1)];
            from_val = (qcmd == rat_pkg::CMD_TO_ADDR) ? wr_start[slot] : wr_base[slot];
            size_val = wr_size[slot];
            case ($urandom_range(0, 5))
                0:       offset = '0;
                1:       offset = size_val;
                2:       offset = size_val + ADDR_W'(1);
                3:       offset = '1;
                default: offset = (&size_val) ? rand64() : rand64() % (size_val + ADDR_W'(1));
            endcase
            send_query(qcmd, from_val + offset);
        end
    endtask

    initial begin : stimulus
        int counted;
        int phase;
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_cmd                = rat_pkg::CMD_WRITE;
        i_entry_index        = '0;
        i_entry_dump_offset  = '0;
        i_entry_dump_size    = '0;
        i_entry_base_address = '0;
        i_query_address      = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, then an ignored command
        send_query(rat_pkg::CMD_TO_ADDR, '0);
        send_query(rat_pkg::CMD_TO_OFFSET, '1);
        send_ignored();
        // Single region: start, inclusive end, past the end, below every start, then both ends the other way
        send_write(0, 64'd100, 64'd50, 64'h1000);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd100);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd150);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd151);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd99);
        send_query(rat_pkg::CMD_TO_OFFSET, 64'h1000);
        send_query(rat_pkg::CMD_TO_OFFSET, 64'h1032);
        // Equal starts: the higher slot wins even where it misses
        send_write(REGION_ENTRIES_DEF - 1, 64'd100, 64'd10, 64'h2000);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd105);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd120);
        // Region end beyond 2^64, then an answer that wraps
        send_write(5, '1 - 64'd3, '1, '0);
        send_query(rat_pkg::CMD_TO_ADDR, '1);
        send_query(rat_pkg::CMD_TO_OFFSET, '0);
        send_write(6, 64'h5000_0000, 64'h100, 64'hFFFF_FFFF_FFFF_FFF0);
        send_query(rat_pkg::CMD_TO_ADDR, 64'h5000_0020);
        // Rewrite a slot with a zero size
        send_write(REGION_ENTRIES_DEF - 1, 64'd200, '0, 64'h3000);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd200);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd201);
        send_query(rat_pkg::CMD_TO_ADDR, 64'd105);
        drain_results();

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            phase = counted * 3 / RANDOM_ITEMS;
            sender_gap(gap_pct[phase]);
            if ($urandom_range(0, 59) == 0) drain_results();
            case ($urandom_range(0, 19))
                0: send_ignored();
                1, 2, 3, 4, 5: begin
                    random_write();
                    counted++;
                end
                default: begin
                    random_query();
                    counted++;
                end
            endcase
        end

        drain_results();
        repeat (DRAIN_CYCLES) idle_cycle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
